// File: hdl/bda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_pkg
// Shared codes, widths and controller/datapath command and status words.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int CMD_BITS      = 3;
  localparam int PID_BITS      = 3;
  localparam int RID_BITS      = 2;
  localparam int AMOUNT_BITS   = 16;
  localparam int STATUS_BITS   = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 4;

  localparam logic [CMD_BITS-1:0] CMD_LOAD_AVAIL = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_ALLOC = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_LOAD_MAX   = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_REQUEST    = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_QUERY      = 3'd4;

  localparam logic [STATUS_BITS-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EXCEEDS  = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_DENIED   = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_UNSAFE   = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PROCS = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RES   = 2'd1;

  typedef struct packed {
    logic                   latch;
    logic                   write_load;
    logic                   write_pend;
    logic                   clr_pend;
    logic                   clr_step;
    logic                   r_clr;
    logic                   r_inc;
    logic                   p_clr;
    logic                   p_inc;
    logic                   k_clr;
    logic                   k_inc;
    logic                   rd;
    logic                   sel_req;
    logic                   chk_req;
    logic                   bad_clr;
    logic                   apply;
    logic                   rollback;
    logic                   work_init;
    logic                   fin_clr;
    logic                   count_clr;
    logic                   found_clr;
    logic                   work_add;
    logic                   take;
    logic                   rd_order;
    logic                   out_load;
    logic                   seq_sel;
    logic                   last;
    logic [STATUS_BITS-1:0] resp;
  } ctl_t;

  typedef struct packed {
    logic                r_last;
    logic                p_last;
    logic                p_fin;
    logic                fit_now;
    logic                bad;
    logic                req_inact;
    logic                count_done;
    logic                found;
    logic                k_last;
    logic                can_load;
    logic                clr_last;
    logic                fin;
    logic [CMD_BITS-1:0] cmd;
  } sts_t;

endpackage

// File: hdl/bda_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_datapath
// Holds the matrices, vectors, counters and the output word register.
// ----------------------------------------------------------------------------
module bda_datapath #(
  parameter int PROCS     = 8,
  parameter int RESOURCES = 4,
  parameter int UNIT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [bda_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [bda_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [bda_pkg::CMD_BITS-1:0]       cmd,
  input  logic [bda_pkg::PID_BITS-1:0]       process_id,
  input  logic [bda_pkg::RID_BITS-1:0]       resource_id,
  input  logic [bda_pkg::AMOUNT_BITS-1:0]    amount,
  input  logic                               final_element,
  input  bda_pkg::ctl_t                      ctl,
  output bda_pkg::sts_t                      sts,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [bda_pkg::STATUS_BITS-1:0]    status,
  output logic [bda_pkg::PID_BITS-1:0]       sequence_process,
  output logic                               last_result
);

  localparam int UW    = UNIT_BITS;
  localparam int WB    = UNIT_BITS + 3;
  localparam int DEPTH = PROCS * RESOURCES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PB    = (PROCS > 1) ? $clog2(PROCS) : 1;
  localparam int RB    = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
  localparam int NPW   = $clog2(PROCS + 1);
  localparam int NRW   = $clog2(RESOURCES + 1);
  localparam logic [WB-1:0] WORK_MAX = '1;

  logic [bda_pkg::CMD_BITS-1:0] cmd_q;
  logic [bda_pkg::PID_BITS-1:0] pid_q;
  logic [bda_pkg::RID_BITS-1:0] rid_q;
  logic [UW-1:0]                amt_q;
  logic                         fin_q;

  logic [3:0] ap;
  logic [2:0] ar;
  logic [NPW-1:0] np;
  logic [NRW-1:0] nr;

  logic [UW-1:0] avail [RESOURCES];
  logic [UW-1:0] pend  [RESOURCES];
  logic [WB-1:0] work  [RESOURCES];
  logic [PROCS-1:0] finished;

  logic [UW-1:0] alloc_mem [DEPTH];
  logic [UW-1:0] max_mem   [DEPTH];
  logic [bda_pkg::PID_BITS-1:0] order_mem [PROCS];
  logic [UW-1:0] alloc_q, max_q;
  logic [bda_pkg::PID_BITS-1:0] order_q;

  logic [RB-1:0]  r_cnt;
  logic [PB-1:0]  p_cnt;
  logic [PB-1:0]  k_cnt;
  logic [NPW-1:0] count;
  logic [AW-1:0]  clr_addr;
  logic           found;
  logic           bad;

  logic [PB-1:0] row;
  logic [AW-1:0] raddr, laddr, waddr;
  logic          p_ok, r_ok;
  logic          alloc_we, max_we;
  logic [UW-1:0] alloc_wd, max_wd;
  logic [UW-1:0] need;
  logic [WB:0]   sum;

  always_comb begin
    if (ap == 4'd0) np = NPW'(1);
    else if (32'(ap) > PROCS) np = NPW'(PROCS);
    else np = NPW'(ap);
    if (ar == 3'd0) nr = NRW'(1);
    else if (32'(ar) > RESOURCES) nr = NRW'(RESOURCES);
    else nr = NRW'(ar);
  end

  assign p_ok  = 32'(pid_q) < PROCS;
  assign r_ok  = 32'(rid_q) < RESOURCES;
  assign row   = ctl.sel_req ? PB'(pid_q) : p_cnt;
  assign raddr = AW'(row) * AW'(RESOURCES) + AW'(r_cnt);
  assign laddr = AW'(PB'(pid_q)) * AW'(RESOURCES) + AW'(RB'(rid_q));
  assign need  = max_q - alloc_q;
  assign sum   = (WB+1)'(work[r_cnt]) + (WB+1)'(alloc_q);

  always_comb begin
    alloc_we = 1'b0;
    max_we   = 1'b0;
    alloc_wd = amt_q;
    max_wd   = amt_q;
    waddr    = raddr;
    if (ctl.clr_step) begin
      alloc_we = 1'b1;
      max_we   = 1'b1;
      alloc_wd = '0;
      max_wd   = '0;
      waddr    = clr_addr;
    end else if (ctl.write_load) begin
      waddr    = laddr;
      alloc_we = (cmd_q == bda_pkg::CMD_LOAD_ALLOC) && p_ok && r_ok;
      max_we   = (cmd_q == bda_pkg::CMD_LOAD_MAX) && p_ok && r_ok;
    end else if (ctl.apply) begin
      alloc_we = 1'b1;
      alloc_wd = alloc_q + pend[r_cnt];
    end else if (ctl.rollback) begin
      alloc_we = 1'b1;
      alloc_wd = alloc_q - pend[r_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (alloc_we) alloc_mem[waddr] <= alloc_wd;
    if (max_we) max_mem[waddr] <= max_wd;
    if (ctl.rd) begin
      alloc_q <= alloc_mem[raddr];
      max_q   <= max_mem[raddr];
    end
    if (ctl.take) order_mem[count[PB-1:0]] <= bda_pkg::PID_BITS'(p_cnt);
    if (ctl.rd_order) order_q <= order_mem[k_cnt];
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q <= cmd;
      pid_q <= process_id;
      rid_q <= resource_id;
      amt_q <= UW'(amount);
      fin_q <= final_element;
    end
    if (ctl.work_init) begin
      for (int i = 0; i < RESOURCES; i++) begin
        work[i] <= (i < 32'(nr)) ? WB'(avail[i]) : '0;
      end
    end else if (ctl.work_add) begin
      work[r_cnt] <= (sum > (WB+1)'(WORK_MAX)) ? WORK_MAX : sum[WB-1:0];
    end
    if (ctl.fin_clr) finished <= '0;
    else if (ctl.take) finished[p_cnt] <= 1'b1;
    if (ctl.count_clr) count <= '0;
    else if (ctl.take) count <= count + NPW'(1);
    if (ctl.found_clr) found <= 1'b0;
    else if (ctl.take) found <= 1'b1;
    if (ctl.bad_clr) bad <= 1'b0;
    else if (ctl.chk_req) begin
      bad <= bad | (max_q < alloc_q) | (pend[r_cnt] > need) | (pend[r_cnt] > avail[r_cnt]);
    end
    if (ctl.r_clr) r_cnt <= '0;
    else if (ctl.r_inc) r_cnt <= r_cnt + RB'(1);
    if (ctl.p_clr) p_cnt <= '0;
    else if (ctl.p_inc) p_cnt <= p_cnt + PB'(1);
    if (ctl.k_clr) k_cnt <= '0;
    else if (ctl.k_inc) k_cnt <= k_cnt + PB'(1);
    if (ctl.out_load) begin
      status           <= ctl.resp;
      sequence_process <= ctl.seq_sel ? order_q : '0;
      last_result      <= ctl.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ap        <= 4'd8;
      ar        <= 3'd4;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < RESOURCES; i++) begin
        avail[i] <= '0;
        pend[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_index == bda_pkg::CFG_PROCS) ap <= cfg_data;
      if (cfg_valid && cfg_index == bda_pkg::CFG_RES) ar <= cfg_data[2:0];
      if (ctl.clr_step) clr_addr <= clr_addr + AW'(1);
      if (ctl.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (ctl.write_load && cmd_q == bda_pkg::CMD_LOAD_AVAIL && r_ok) begin
        avail[RB'(rid_q)] <= amt_q;
      end else if (ctl.apply) begin
        avail[r_cnt] <= avail[r_cnt] - pend[r_cnt];
      end else if (ctl.rollback) begin
        avail[r_cnt] <= avail[r_cnt] + pend[r_cnt];
      end
      if (ctl.clr_pend) begin
        for (int i = 0; i < RESOURCES; i++) pend[i] <= '0;
      end else if (ctl.write_pend && r_ok) begin
        pend[RB'(rid_q)] <= amt_q;
      end
    end
  end

  always_comb begin
    sts.r_last     = (32'(r_cnt) + 1) == 32'(nr);
    sts.p_last     = (32'(p_cnt) + 1) == 32'(np);
    sts.p_fin      = finished[p_cnt];
    sts.fit_now    = (max_q <= alloc_q) || (WB'(need) <= work[r_cnt]);
    sts.bad        = bad;
    sts.req_inact  = !p_ok || !(32'(pid_q) < 32'(np));
    sts.count_done = count == np;
    sts.found      = found;
    sts.k_last     = (32'(k_cnt) + 1) == 32'(np);
    sts.can_load   = !out_valid || out_ready;
    sts.clr_last   = clr_addr == AW'(DEPTH - 1);
    sts.fin        = fin_q;
    sts.cmd        = cmd_q;
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("output word overwritten");
  a_take_marks: assert property (@(posedge clk) disable iff (rst)
    ctl.take |=> finished[$past(p_cnt)])
    else $error("taken process not marked finished");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.take |-> (count < np))
    else $error("safe sequence longer than active processes");
  a_apply_ok: assert property (@(posedge clk) disable iff (rst)
    ctl.apply |-> !bad)
    else $error("request applied after failing the limit check");

endmodule

// File: hdl/bda_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bda_controller
// Sequencer for loads, request checking, the safety scan and result output.
// ----------------------------------------------------------------------------
module bda_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  bda_pkg::sts_t sts,
  output bda_pkg::ctl_t ctl
);

  localparam logic [4:0] S_CLEAR     = 5'd0;
  localparam logic [4:0] S_IDLE      = 5'd1;
  localparam logic [4:0] S_DISP      = 5'd2;
  localparam logic [4:0] S_REQ_RD    = 5'd3;
  localparam logic [4:0] S_REQ_CHK   = 5'd4;
  localparam logic [4:0] S_REQ_DEC   = 5'd5;
  localparam logic [4:0] S_APP_RD    = 5'd6;
  localparam logic [4:0] S_APP_WR    = 5'd7;
  localparam logic [4:0] S_SAFE_INIT = 5'd8;
  localparam logic [4:0] S_SCAN      = 5'd9;
  localparam logic [4:0] S_FIT_RD    = 5'd10;
  localparam logic [4:0] S_FIT_CHK   = 5'd11;
  localparam logic [4:0] S_ADD_RD    = 5'd12;
  localparam logic [4:0] S_ADD_WR    = 5'd13;
  localparam logic [4:0] S_NEXTP     = 5'd14;
  localparam logic [4:0] S_END_PASS  = 5'd15;
  localparam logic [4:0] S_RB_RD     = 5'd16;
  localparam logic [4:0] S_RB_WR     = 5'd17;
  localparam logic [4:0] S_RESP      = 5'd18;
  localparam logic [4:0] S_OUT_RD    = 5'd19;
  localparam logic [4:0] S_OUT_WAIT  = 5'd20;

  logic [4:0] state, state_next;
  logic [bda_pkg::STATUS_BITS-1:0] resp, resp_next;
  logic query;

  assign query    = sts.cmd == bda_pkg::CMD_QUERY;
  assign in_ready = state == S_IDLE;

  always_comb begin
    state_next = state;
    resp_next  = resp;
    ctl        = '0;
    ctl.resp   = resp;
    unique case (state)
      S_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ctl.latch = in_valid;
        if (in_valid) state_next = S_DISP;
      end
      S_DISP: begin
        unique case (sts.cmd) inside
          bda_pkg::CMD_LOAD_AVAIL, bda_pkg::CMD_LOAD_ALLOC, bda_pkg::CMD_LOAD_MAX: begin
            ctl.write_load = 1'b1;
            resp_next      = bda_pkg::ST_OK;
            state_next     = S_RESP;
          end
          bda_pkg::CMD_REQUEST: begin
            ctl.write_pend = 1'b1;
            if (!sts.fin) state_next = S_IDLE;
            else if (sts.req_inact) begin
              resp_next  = bda_pkg::ST_EXCEEDS;
              state_next = S_RESP;
            end else begin
              ctl.r_clr   = 1'b1;
              ctl.bad_clr = 1'b1;
              state_next  = S_REQ_RD;
            end
          end
          bda_pkg::CMD_QUERY: state_next = S_SAFE_INIT;
          default: state_next = S_IDLE;
        endcase
      end
      S_REQ_RD: begin
        ctl.rd      = 1'b1;
        ctl.sel_req = 1'b1;
        state_next  = S_REQ_CHK;
      end
      S_REQ_CHK: begin
        ctl.chk_req = 1'b1;
        if (sts.r_last) state_next = S_REQ_DEC;
        else begin
          ctl.r_inc  = 1'b1;
          state_next = S_REQ_RD;
        end
      end
      S_REQ_DEC: begin
        if (sts.bad) begin
          resp_next  = bda_pkg::ST_EXCEEDS;
          state_next = S_RESP;
        end else begin
          ctl.r_clr  = 1'b1;
          state_next = S_APP_RD;
        end
      end
      S_APP_RD: begin
        ctl.rd      = 1'b1;
        ctl.sel_req = 1'b1;
        state_next  = S_APP_WR;
      end
      S_APP_WR: begin
        ctl.apply   = 1'b1;
        ctl.sel_req = 1'b1;
        if (sts.r_last) state_next = S_SAFE_INIT;
        else begin
          ctl.r_inc  = 1'b1;
          state_next = S_APP_RD;
        end
      end
      S_SAFE_INIT: begin
        ctl.work_init = 1'b1;
        ctl.fin_clr   = 1'b1;
        ctl.count_clr = 1'b1;
        ctl.found_clr = 1'b1;
        ctl.p_clr     = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (sts.p_fin) state_next = S_NEXTP;
        else begin
          ctl.r_clr  = 1'b1;
          state_next = S_FIT_RD;
        end
      end
      S_FIT_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_FIT_CHK;
      end
      S_FIT_CHK: begin
        if (!sts.fit_now) state_next = S_NEXTP;
        else if (sts.r_last) begin
          ctl.r_clr  = 1'b1;
          state_next = S_ADD_RD;
        end else begin
          ctl.r_inc  = 1'b1;
          state_next = S_FIT_RD;
        end
      end
      S_ADD_RD: begin
        ctl.rd     = 1'b1;
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        ctl.work_add = 1'b1;
        if (sts.r_last) begin
          ctl.take   = 1'b1;
          state_next = S_NEXTP;
        end else begin
          ctl.r_inc  = 1'b1;
          state_next = S_ADD_RD;
        end
      end
      S_NEXTP: begin
        if (sts.p_last) state_next = S_END_PASS;
        else begin
          ctl.p_inc  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_END_PASS: begin
        if (!sts.found) begin
          if (query) begin
            resp_next  = bda_pkg::ST_UNSAFE;
            state_next = S_RESP;
          end else begin
            ctl.r_clr  = 1'b1;
            state_next = S_RB_RD;
          end
        end else if (sts.count_done) begin
          if (query) begin
            ctl.k_clr  = 1'b1;
            state_next = S_OUT_RD;
          end else begin
            resp_next  = bda_pkg::ST_OK;
            state_next = S_RESP;
          end
        end else begin
          ctl.found_clr = 1'b1;
          ctl.p_clr     = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_RB_RD: begin
        ctl.rd      = 1'b1;
        ctl.sel_req = 1'b1;
        state_next  = S_RB_WR;
      end
      S_RB_WR: begin
        ctl.rollback = 1'b1;
        ctl.sel_req  = 1'b1;
        if (sts.r_last) begin
          resp_next  = bda_pkg::ST_DENIED;
          state_next = S_RESP;
        end else begin
          ctl.r_inc  = 1'b1;
          state_next = S_RB_RD;
        end
      end
      S_RESP: begin
        if (sts.can_load) begin
          ctl.out_load = 1'b1;
          ctl.last     = 1'b1;
          ctl.clr_pend = sts.cmd == bda_pkg::CMD_REQUEST;
          state_next   = S_IDLE;
        end
      end
      S_OUT_RD: begin
        ctl.rd_order = 1'b1;
        state_next   = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (sts.can_load) begin
          ctl.out_load = 1'b1;
          ctl.resp     = bda_pkg::ST_OK;
          ctl.seq_sel  = 1'b1;
          ctl.last     = sts.k_last;
          if (sts.k_last) state_next = S_IDLE;
          else begin
            ctl.k_inc  = 1'b1;
            state_next = S_OUT_RD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      resp  <= bda_pkg::ST_OK;
    end else begin
      state <= state_next;
      resp  <= resp_next;
    end
  end

  a_apply_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ctl.apply && ctl.rollback))
    else $error("apply and rollback together");
  a_ready_idle_only: assert property (@(posedge clk) disable iff (rst)
    ctl.latch |=> (state == S_DISP))
    else $error("word latched outside idle");
  a_out_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && ctl.out_load) |-> ctl.last)
    else $error("single response not marked last");

endmodule

// File: hdl/bankers_deadlock_avoidance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bankers_deadlock_avoidance
// Loads are latched, written and answered; request elements latched and stored;
// judged requests and queries test each process, over up to PROCS passes of PROCS.
// A query emits its sequence words in turn. One word in flight at a time.
// Reset: synchronous; a sweep over all PROCS*RESOURCES entries zeroes both matrices
// before the first word is taken. Configuration is taken at any time.
// ----------------------------------------------------------------------------
module bankers_deadlock_avoidance #(
  parameter int PROCS     = 8,
  parameter int RESOURCES = 4,
  parameter int UNIT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bda_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [bda_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bda_pkg::CMD_BITS-1:0]      cmd,
  input  logic [bda_pkg::PID_BITS-1:0]      process_id,
  input  logic [bda_pkg::RID_BITS-1:0]      resource_id,
  input  logic [bda_pkg::AMOUNT_BITS-1:0]   amount,
  input  logic                              final_element,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bda_pkg::STATUS_BITS-1:0]   status,
  output logic [bda_pkg::PID_BITS-1:0]      sequence_process,
  output logic                              last_result
);

  bda_pkg::ctl_t ctl;
  bda_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  bda_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bda_datapath #(
    .PROCS     (PROCS),
    .RESOURCES (RESOURCES),
    .UNIT_BITS (UNIT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .process_id       (process_id),
    .resource_id      (resource_id),
    .amount           (amount),
    .final_element    (final_element),
    .ctl              (ctl),
    .sts              (sts),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .status           (status),
    .sequence_process (sequence_process),
    .last_result      (last_result)
  );

endmodule
